### rtl/ddpc_pkg.sv
`timescale 1ns / 1ps

package ddpc_pkg;

  // Fixed-point format: Q3.13 values in QW bits, intermediate math in WW bits
  localparam int unsigned FRAC_BITS = 13;
  localparam int unsigned PWM_W     = 16;
  localparam int unsigned QW        = FRAC_BITS + 3;
  localparam int unsigned WW        = QW + 8;
  localparam int unsigned AW        = QW + 2;
  localparam int unsigned BW        = 16;
  localparam int unsigned PW        = AW + BW + 1;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  localparam longint      PI_Q30 = 64'sd3373259426;
  localparam int unsigned PI_SH  = 30 - FRAC_BITS;
  localparam longint      ONE_L  = longint'(1) << FRAC_BITS;
  localparam longint      PI_L   = (PI_Q30 + (longint'(1) << (PI_SH - 1))) >> PI_SH;

  // Degrees to radians: scale by pi / 180 in the Q30 domain, rounded
  localparam longint      HEAD_RND = longint'(90) << PI_SH;
  localparam longint      HEAD_DIV = longint'(180) << PI_SH;

  localparam logic signed [WW-1:0] ONE    = WW'(ONE_L);
  localparam logic signed [WW-1:0] PI     = WW'(PI_L);
  localparam logic signed [WW-1:0] TWO_PI = WW'(2 * PI_L);
  localparam logic signed [WW-1:0] DEAD   = WW'((5 * ONE_L + 50) / 100);
  localparam logic signed [WW-1:0] LIMIT  = WW'((99 * ONE_L + 50) / 100);
  localparam logic signed [WW-1:0] QMAX   = WW'(4 * ONE_L - 1);
  localparam logic signed [WW-1:0] QMIN   = WW'(-4 * ONE_L);
  localparam logic signed [PW-1:0] HALF   = PW'(longint'(1) << (FRAC_BITS - 1));
  localparam logic [15:0]          PWM_MASK = 16'((64'd1 << PWM_W) - 64'd1);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TURN_GAIN,
    REG_HALF_TICK,
    REG_SPEED_FB,
    REG_SPEED_CMD,
    REG_HEAD_GAIN,
    REG_TURN_DAMP,
    REG_PWM_TOP
  } cfg_reg_e;

  localparam logic [BW-1:0] RST_TURN_GAIN = 16'd8192;
  localparam logic [BW-1:0] RST_HALF_TICK = 16'd82;
  localparam logic [BW-1:0] RST_SPEED_FB  = 16'd8192;
  localparam logic [BW-1:0] RST_SPEED_CMD = 16'd8192;
  localparam logic [BW-1:0] RST_HEAD_GAIN = 16'd8192;
  localparam logic [BW-1:0] RST_TURN_DAMP = 16'd8192;
  localparam logic [BW-1:0] RST_PWM_TOP   = 16'd10000;

  typedef enum logic [1:0] {
    DIR_NEUTRAL = 2'd0,
    DIR_FORWARD = 2'd1,
    DIR_REVERSE = 2'd2
  } dir_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_W,
    ST_SUM_W,
    ST_MUL_H,
    ST_HEAD,
    ST_ERR,
    ST_DAMP,
    ST_ANG,
    ST_LIMIT,
    ST_HEADROOM,
    ST_DUTY,
    ST_CMP_R,
    ST_CMP_L,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic [7:0]         speed_command;
    logic [7:0]         heading_command;
    logic signed [15:0] left_speed;
    logic signed [15:0] right_speed;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  right_direction;
    logic [1:0]  left_direction;
    logic [15:0] right_compare;
    logic [15:0] left_compare;
  } out_item_t;

  typedef logic signed [QW-1:0] cmd_lut_t [256];
  typedef logic [QW-1:0]        head_lut_t [128];

  // Speed byte minus 100, over 100, rounded half away from zero
  function automatic cmd_lut_t build_cmd_lut();
    cmd_lut_t lut;
    longint   raw;
    longint   v;
    for (int i = 0; i < 256; i++) begin
      raw = longint'(i) - 100;
      if (raw >= 0) begin
        v = (raw * ONE_L + 50) / 100;
      end else begin
        v = -((-raw * ONE_L + 50) / 100);
      end
      lut[i] = QW'(v);
    end
    return lut;
  endfunction

  // Whole degrees to radians
  function automatic head_lut_t build_head_lut();
    head_lut_t lut;
    longint    v;
    for (int i = 0; i < 128; i++) begin
      v = (longint'(i) * PI_Q30 + HEAD_RND) / HEAD_DIV;
      lut[i] = QW'(v);
    end
    return lut;
  endfunction

  localparam cmd_lut_t  CMD_LUT  = build_cmd_lut();
  localparam head_lut_t HEAD_LUT = build_head_lut();

  function automatic logic signed [QW-1:0] sat_q(input logic signed [WW-1:0] x);
    if (x > QMAX) begin
      return QMAX[QW-1:0];
    end else if (x < QMIN) begin
      return QMIN[QW-1:0];
    end
    return x[QW-1:0];
  endfunction

  // Drop the fraction of a product, rounding half up
  function automatic logic signed [WW-1:0] rnd_q(input logic signed [PW-1:0] p);
    logic signed [PW-1:0] t;
    t = (p + HALF) >>> FRAC_BITS;
    return t[WW-1:0];
  endfunction

  function automatic logic signed [WW-1:0] abs_w(input logic signed [WW-1:0] x);
    return (x < 0) ? -x : x;
  endfunction

  function automatic logic signed [WW-1:0] clamp_w(input logic signed [WW-1:0] x,
                                                  input logic signed [WW-1:0] m);
    if (x > m) begin
      return m;
    end else if (x < -m) begin
      return -m;
    end
    return x;
  endfunction

  function automatic logic [1:0] dir_of(input logic signed [QW-1:0] d);
    if (d > 0) begin
      return DIR_FORWARD;
    end else if (d < 0) begin
      return DIR_REVERSE;
    end
    return DIR_NEUTRAL;
  endfunction

  function automatic logic [15:0] cmp_of(input logic signed [PW-1:0] p);
    logic [PW-1:0] s;
    s = p >> FRAC_BITS;
    return s[15:0] & PWM_MASK;
  endfunction

endpackage

### rtl/differential_drive_pwm_controller.sv
`timescale 1ns / 1ps

// Heading and speed controller for a two-wheel drive. Each input beat is one control tick:
// speed and heading command bytes plus the measured wheel speeds; each tick yields exactly one
// output beat with a direction and PWM compare value per wheel. All math is Q3.13 through one
// shared 18x17 multiplier, used eight times per tick under a fixed sequencer. The result beat
// is valid in the same cycle in which in_ready_o returns, so a new input beat is accepted only
// once the previous result is loaded; a stalled output holds the sequencer in its last step.
// Configuration writes take effect at once and belong between ticks; the heading estimate and
// previous turn rate reset to zero.
module differential_drive_pwm_controller (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  ddpc_pkg::in_item_t                  in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output ddpc_pkg::out_item_t                 out_data_o,
  input  logic                                cfg_we_i,
  input  logic [ddpc_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [ddpc_pkg::CFG_DATA_W-1:0]     cfg_data_i
);
  import ddpc_pkg::*;

  state_e state_q, state_d;

  logic [BW-1:0] turn_gain_q, half_tick_q, speed_fb_q, speed_cmd_q;
  logic [BW-1:0] head_gain_q, turn_damp_q, pwm_top_q;

  logic                 mul_en;
  logic signed [AW-1:0] op_a;
  logic [BW-1:0]        op_b;
  logic signed [PW-1:0] prod_q;

  logic signed [QW-1:0] cmd_q, vt_q, w_q, err_q, ut_q, ua_q, dr_q, dl_q;
  logic [QW-1:0]        target_q, heading_q;
  logic signed [QW:0]   dv_q;
  logic signed [AW-1:0] opa_q;
  logic signed [WW-1:0] acc_q;
  logic [15:0]          rc_q;
  out_item_t            out_q;
  logic                 out_valid_q;
  logic                 out_load;
  logic                 in_fire;

  logic signed [QW-1:0] vl_c, vr_c, w_new, inc;
  logic signed [QW:0]   vsum;
  logic signed [WW-1:0] h_sum, h_wrap, t_w, h_w, err_raw;
  logic signed [WW-1:0] aua, ua_lim, room, ut_room;

  assign in_fire = in_valid_i & in_ready_o;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      turn_gain_q <= RST_TURN_GAIN;
      half_tick_q <= RST_HALF_TICK;
      speed_fb_q  <= RST_SPEED_FB;
      speed_cmd_q <= RST_SPEED_CMD;
      head_gain_q <= RST_HEAD_GAIN;
      turn_damp_q <= RST_TURN_DAMP;
      pwm_top_q   <= RST_PWM_TOP;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_TURN_GAIN: turn_gain_q <= cfg_data_i;
        REG_HALF_TICK: half_tick_q <= cfg_data_i;
        REG_SPEED_FB:  speed_fb_q  <= cfg_data_i;
        REG_SPEED_CMD: speed_cmd_q <= cfg_data_i;
        REG_HEAD_GAIN: head_gain_q <= cfg_data_i;
        REG_TURN_DAMP: turn_damp_q <= cfg_data_i;
        REG_PWM_TOP:   pwm_top_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    mul_en     = 1'b0;
    op_a       = '0;
    op_b       = '0;
    in_ready_o = 1'b0;
    out_load   = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          state_d = ST_MUL_W;
        end
      end
      ST_MUL_W: begin
        mul_en  = 1'b1;
        op_a    = AW'(dv_q);
        op_b    = turn_gain_q;
        state_d = ST_SUM_W;
      end
      ST_SUM_W: begin
        mul_en  = 1'b1;
        op_a    = AW'(cmd_q);
        op_b    = speed_cmd_q;
        state_d = ST_MUL_H;
      end
      ST_MUL_H: begin
        mul_en  = 1'b1;
        op_a    = opa_q;
        op_b    = half_tick_q;
        state_d = ST_HEAD;
      end
      ST_HEAD: begin
        mul_en  = 1'b1;
        op_a    = AW'(vt_q);
        op_b    = speed_fb_q;
        state_d = ST_ERR;
      end
      ST_ERR: begin
        mul_en  = 1'b1;
        op_a    = AW'(w_q);
        op_b    = turn_damp_q;
        state_d = ST_DAMP;
      end
      ST_DAMP: begin
        mul_en  = 1'b1;
        op_a    = AW'(err_q);
        op_b    = head_gain_q;
        state_d = ST_ANG;
      end
      ST_ANG:      state_d = ST_LIMIT;
      ST_LIMIT:    state_d = ST_HEADROOM;
      ST_HEADROOM: state_d = ST_DUTY;
      ST_DUTY:     state_d = ST_CMP_R;
      ST_CMP_R: begin
        mul_en  = 1'b1;
        op_a    = AW'((dr_q < 0) ? -dr_q : dr_q);
        op_b    = pwm_top_q;
        state_d = ST_CMP_L;
      end
      ST_CMP_L: begin
        mul_en  = 1'b1;
        op_a    = AW'((dl_q < 0) ? -dl_q : dl_q);
        op_b    = pwm_top_q;
        state_d = ST_DONE;
      end
      ST_DONE: begin
        // hold until the output register is free
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Input conditioning
  always_comb begin
    vl_c = QW'(clamp_w(WW'(in_data_i.left_speed), ONE));
    vr_c = QW'(clamp_w(WW'(in_data_i.right_speed), ONE));
    vsum = (QW+1)'(vr_c) + (QW+1)'(vl_c) + (QW+1)'(1);
  end

  // Post-processing of the product register and the limit chain
  always_comb begin
    w_new = sat_q(rnd_q(prod_q));
    inc   = sat_q(rnd_q(prod_q));

    h_sum = $signed(WW'(heading_q)) + WW'(inc);
    if (h_sum > TWO_PI) begin
      h_wrap = h_sum - TWO_PI;
    end else if (h_sum < 0) begin
      h_wrap = h_sum + TWO_PI;
    end else begin
      h_wrap = h_sum;
    end

    // shortest way around to the target
    t_w = $signed(WW'(target_q));
    h_w = $signed(WW'(heading_q));
    if (t_w >= PI + h_w) begin
      err_raw = t_w - TWO_PI - h_w;
    end else if (t_w <= h_w - PI) begin
      err_raw = t_w + TWO_PI - h_w;
    end else begin
      err_raw = t_w - h_w;
    end

    aua = abs_w(WW'(ua_q));
    if (aua > ONE) begin
      ua_lim = (ua_q < 0) ? -ONE : ONE;
    end else if (aua <= DEAD) begin
      ua_lim = '0;
    end else begin
      ua_lim = WW'(ua_q);
    end

    room = ONE - abs_w(WW'(ua_q));
    if (abs_w(WW'(ut_q)) > room) begin
      ut_room = (ut_q < 0) ? -room : room;
    end else begin
      ut_room = WW'(ut_q);
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      heading_q   <= '0;
      w_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (state_q == ST_SUM_W) begin
        w_q <= w_new;
      end
      if (state_q == ST_HEAD) begin
        heading_q <= h_wrap[QW-1:0];
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    if (mul_en) begin
      prod_q <= op_a * $signed({1'b0, op_b});
    end
    if (in_fire) begin
      cmd_q    <= CMD_LUT[in_data_i.speed_command];
      target_q <= HEAD_LUT[in_data_i.heading_command[7:1]];
      dv_q     <= (QW+1)'(vr_c) - (QW+1)'(vl_c);
      vt_q     <= vsum[QW:1];
    end
    case (state_q)
      ST_SUM_W:    opa_q <= AW'(w_new) + AW'(w_q);
      ST_MUL_H:    acc_q <= rnd_q(prod_q);
      ST_ERR: begin
        ut_q  <= sat_q(acc_q - rnd_q(prod_q));
        err_q <= sat_q(err_raw);
      end
      ST_DAMP:     acc_q <= rnd_q(prod_q);
      ST_ANG:      ua_q  <= sat_q(rnd_q(prod_q) - acc_q);
      ST_LIMIT: begin
        ua_q <= ua_lim[QW-1:0];
        ut_q <= QW'(clamp_w(WW'(ut_q), ONE));
      end
      ST_HEADROOM: ut_q  <= ut_room[QW-1:0];
      ST_DUTY: begin
        dr_q <= QW'(clamp_w(WW'(ut_q) + WW'(ua_q), LIMIT));
        dl_q <= QW'(clamp_w(WW'(ut_q) - WW'(ua_q), LIMIT));
      end
      ST_CMP_L:    rc_q  <= cmp_of(prod_q);
      default: ;
    endcase
    if (out_load) begin
      out_q.right_direction <= dir_of(dr_q);
      out_q.left_direction  <= dir_of(dl_q);
      out_q.right_compare   <= rc_q;
      out_q.left_compare    <= cmp_of(prod_q);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef NO_ASSERTIONS
  a_heading_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $signed(WW'(heading_q)) <= TWO_PI)
    else $error("heading estimate beyond two pi");

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> state_q == ST_MUL_W)
    else $error("accepted beat did not start the sequence");

  a_result_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == ST_DONE)
    else $error("result raised outside the final step");

  a_duty_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_CMP_R |-> (WW'(dr_q) <= LIMIT && WW'(dr_q) >= -LIMIT &&
                             WW'(dl_q) <= LIMIT && WW'(dl_q) >= -LIMIT))
    else $error("duty beyond limit");

  a_hold_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE && out_valid_q && !out_ready_i) |=> state_q == ST_DONE)
    else $error("result overwrote a pending beat");
`endif

endmodule
